// File: rtl/core/jpgdqt_pkg.sv
package jpgdqt_pkg;

   // marker code bytes
   localparam logic [7:0] PREFIX_CODE = 8'hFF;
   localparam logic [7:0] SOI_CODE    = 8'hD8;
   localparam logic [7:0] APP0_CODE   = 8'hE0;
   localparam logic [7:0] APPN_FIRST  = 8'hE1;
   localparam logic [7:0] APPN_LAST   = 8'hEF;
   localparam logic [7:0] DQT_CODE    = 8'hDB;
   localparam logic [7:0] SOF0_CODE   = 8'hC0;
   localparam logic [7:0] DHT_CODE    = 8'hC4;
   localparam logic [7:0] SOS_CODE    = 8'hDA;
   localparam logic [7:0] EOI_CODE    = 8'hD9;

   localparam int TABLE_DEPTH = 64;
   localparam int INDEX_WIDTH = $clog2(TABLE_DEPTH);

   typedef enum logic [2:0] {
      CLASS_SOI  = 3'd0,
      CLASS_APP0 = 3'd1,
      CLASS_APPN = 3'd2,
      CLASS_DQT  = 3'd3,
      CLASS_SOF0 = 3'd4,
      CLASS_DHT  = 3'd5,
      CLASS_SOS  = 3'd6,
      CLASS_EOI  = 3'd7
   } marker_class_type;

   typedef enum logic {
      KIND_EVENT = 1'b0,
      KIND_ELEMENT = 1'b1
   } result_kind_type;

   typedef struct packed {
      logic             known;
      marker_class_type mclass;
   } marker_info_type;

   // controller to datapath
   typedef struct packed {
      logic event_load;   // load a marker event into the result register
      logic info_latch;   // latch precision and table id, restart zigzag count
      logic value_write;  // store one value at the current zigzag position
      logic dump_read;    // read the next row-major entry into the result register
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic             byte_is_prefix;
      logic             code_known;
      marker_class_type code_class;
      logic             zigzag_last;
      logic             dump_last;
   } dp_status_type;

   // zigzag position to natural (row-major) index
   localparam logic [INDEX_WIDTH-1:0] ZIGZAG_TO_NATURAL [TABLE_DEPTH] = '{
       6'd0,  6'd1,  6'd8, 6'd16,  6'd9,  6'd2,  6'd3, 6'd10,
      6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11,  6'd4,  6'd5,
      6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
      6'd27, 6'd20, 6'd13,  6'd6,  6'd7, 6'd14, 6'd21, 6'd28,
      6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
      6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
      6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
      6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
   };

   function automatic marker_info_type classify(input logic [7:0] code);
      marker_info_type info;
      info.known  = 1'b1;
      info.mclass = CLASS_SOI;
      case (code) inside
         SOI_CODE:                 info.mclass = CLASS_SOI;
         APP0_CODE:                info.mclass = CLASS_APP0;
         [APPN_FIRST:APPN_LAST]:   info.mclass = CLASS_APPN;
         DQT_CODE:                 info.mclass = CLASS_DQT;
         SOF0_CODE:                info.mclass = CLASS_SOF0;
         DHT_CODE:                 info.mclass = CLASS_DHT;
         SOS_CODE:                 info.mclass = CLASS_SOS;
         EOI_CODE:                 info.mclass = CLASS_EOI;
         default:                  info.known  = 1'b0;
      endcase
      return info;
   endfunction

endpackage

// File: rtl/core/jpgdqt_dp.sv
module jpgdqt_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [7:0]                    data_byte,
   input  jpgdqt_pkg::dp_cmd_type        cmd,
   output jpgdqt_pkg::dp_status_type     status,
   output logic                          result_kind,
   output logic [2:0]                    marker_class,
   output logic [7:0]                    marker_code,
   output logic [3:0]                    table_number,
   output logic [3:0]                    table_precision,
   output logic [7:0]                    quant_value,
   output logic [2:0]                    row_index,
   output logic [2:0]                    col_index,
   output logic                          last_of_run
);

   localparam int IW = jpgdqt_pkg::INDEX_WIDTH;

   logic [7:0] quant_mem [jpgdqt_pkg::TABLE_DEPTH];

   logic [IW-1:0] zigzag_ff, zigzag_in;
   logic [IW-1:0] dump_ff, dump_in;
   logic [3:0]    number_ff;
   logic [3:0]    precision_ff;
   logic [7:0]    value_ff;
   logic          kind_ff;
   logic [2:0]    class_ff;
   logic [7:0]    code_ff;
   logic [IW-1:0] index_ff;
   logic          last_ff;

   jpgdqt_pkg::marker_info_type info;

   assign info = jpgdqt_pkg::classify(data_byte);

   assign status.byte_is_prefix = (data_byte == jpgdqt_pkg::PREFIX_CODE);
   assign status.code_known     = info.known;
   assign status.code_class     = info.mclass;
   assign status.zigzag_last    = (zigzag_ff == IW'(jpgdqt_pkg::TABLE_DEPTH - 1));
   assign status.dump_last      = (dump_ff == IW'(jpgdqt_pkg::TABLE_DEPTH - 1));

   always_comb begin
      zigzag_in = zigzag_ff;
      dump_in   = dump_ff;
      if (cmd.info_latch) begin
         zigzag_in = '0;
      end else if (cmd.value_write) begin
         zigzag_in = zigzag_ff + 1'b1;
      end
      if (cmd.dump_read) begin
         dump_in = dump_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zigzag_ff    <= '0;
         dump_ff      <= '0;
         number_ff    <= '0;
         precision_ff <= '0;
      end else begin
         zigzag_ff <= zigzag_in;
         dump_ff   <= dump_in;
         if (cmd.info_latch) begin
            precision_ff <= data_byte[7:4];
            number_ff    <= data_byte[3:0];
         end
      end
   end

   // table store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.value_write) begin
         quant_mem[jpgdqt_pkg::ZIGZAG_TO_NATURAL[zigzag_ff]] <= data_byte;
      end
      if (cmd.dump_read) begin
         value_ff <= quant_mem[dump_ff];
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.event_load) begin
         kind_ff  <= jpgdqt_pkg::KIND_EVENT;
         class_ff <= info.mclass;
         code_ff  <= data_byte;
         index_ff <= '0;
         last_ff  <= 1'b1;
      end else if (cmd.dump_read) begin
         kind_ff  <= jpgdqt_pkg::KIND_ELEMENT;
         class_ff <= jpgdqt_pkg::CLASS_DQT;
         code_ff  <= jpgdqt_pkg::DQT_CODE;
         index_ff <= dump_ff;
         last_ff  <= status.dump_last;
      end
   end

   assign result_kind     = kind_ff;
   assign marker_class    = class_ff;
   assign marker_code     = code_ff;
   assign table_number    = kind_ff ? number_ff : 4'd0;
   assign table_precision = kind_ff ? precision_ff : 4'd0;
   assign quant_value     = kind_ff ? value_ff : 8'd0;
   assign row_index       = index_ff[IW-1:IW-3];
   assign col_index       = index_ff[2:0];
   assign last_of_run     = last_ff;

endmodule

// File: rtl/core/jpgdqt_ctrl.sv
module jpgdqt_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  jpgdqt_pkg::dp_status_type     status,
   output jpgdqt_pkg::dp_cmd_type        cmd
);

   typedef enum logic [2:0] {
      ST_SCAN,
      ST_LEN_HI,
      ST_LEN_LO,
      ST_INFO,
      ST_VALUES,
      ST_DUMP
   } state_type;

   state_type state_ff, state_in;
   logic      pending_ff, pending_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;

   // result register can take a new entry
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff != ST_DUMP) && out_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      pending_in   = pending_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_SCAN: begin
            if (accept) begin
               if (!pending_ff) begin
                  pending_in = status.byte_is_prefix;
               end else if (!status.byte_is_prefix) begin
                  pending_in = 1'b0;
                  if (status.code_known) begin
                     cmd.event_load = 1'b1;
                     rsp_valid_in   = 1'b1;
                     if (status.code_class == jpgdqt_pkg::CLASS_DQT) begin
                        state_in = ST_LEN_HI;
                     end
                  end
               end
            end
         end
         ST_LEN_HI: begin
            if (accept) begin
               state_in = ST_LEN_LO;
            end
         end
         ST_LEN_LO: begin
            if (accept) begin
               state_in = ST_INFO;
            end
         end
         ST_INFO: begin
            if (accept) begin
               cmd.info_latch = 1'b1;
               state_in       = ST_VALUES;
            end
         end
         ST_VALUES: begin
            if (accept) begin
               cmd.value_write = 1'b1;
               if (status.zigzag_last) begin
                  state_in = ST_DUMP;
               end
            end
         end
         ST_DUMP: begin
            if (out_free) begin
               cmd.dump_read = 1'b1;
               rsp_valid_in  = 1'b1;
               if (status.dump_last) begin
                  state_in = ST_SCAN;
               end
            end
         end
         default: begin
            state_in   = ST_SCAN;
            pending_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SCAN;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/core/jpeg_marker_scan_dqt_load_core.sv
// a marker event is presented in the cycle after the code byte's transfer
// throughput: one byte per cycle in scan or table load while results drain
// a table dump sends 64 elements as they are taken, fed by the single
// registered read port of the 64-entry store; input is held off meanwhile
// reset (synchronous, active high) returns to scanning with no prefix pending
module jpeg_marker_scan_dqt_load_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_result_kind,
   output logic [2:0] rsp_marker_class,
   output logic [7:0] rsp_marker_code,
   output logic [3:0] rsp_table_number,
   output logic [3:0] rsp_table_precision,
   output logic [7:0] rsp_quant_value,
   output logic [2:0] rsp_row_index,
   output logic [2:0] rsp_col_index,
   output logic       rsp_last_of_run
);

   // commands from the sequencer, status back from the datapath
   jpgdqt_pkg::dp_cmd_type    cmd;
   jpgdqt_pkg::dp_status_type status;

   // sequencer: scan for prefix and code, walk the dqt header, run the dump
   jpgdqt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: code decode, zigzag store, result register
   jpgdqt_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .data_byte       (req_data_byte),
      .cmd             (cmd),
      .status          (status),
      .result_kind     (rsp_result_kind),
      .marker_class    (rsp_marker_class),
      .marker_code     (rsp_marker_code),
      .table_number    (rsp_table_number),
      .table_precision (rsp_table_precision),
      .quant_value     (rsp_quant_value),
      .row_index       (rsp_row_index),
      .col_index       (rsp_col_index),
      .last_of_run     (rsp_last_of_run)
   );

endmodule

// File: tb/sv/jpeg_marker_scan_dqt_load_core_tb.sv
`timescale 1ns / 100ps

module jpeg_marker_scan_dqt_load_core_tb;

   // parser phases of the local predictor
   typedef enum logic [2:0] {
      SCAN_MARKERS = 3'd0,
      SKIP_LEN_HI  = 3'd1,
      SKIP_LEN_LO  = 3'd2,
      TAKE_INFO    = 3'd3,
      TAKE_VALUES  = 3'd4
   } parse_phase_type;

   // one result transfer as the block should present it
   typedef struct {
      jpgdqt_pkg::result_kind_type  kind;
      jpgdqt_pkg::marker_class_type mclass;
      logic [7:0]                   code;
      logic [3:0]                   tbl_num;
      logic [3:0]                   precision;
      logic [7:0]                   value;
      logic [2:0]                   row;
      logic [2:0]                   col;
      logic                         last;
   } scan_result_type;

   // bytes are added until the stream holds at least this many, directed part included
   localparam int STREAM_ITEMS = 220;
   // marker, two length bytes, info byte and 64 values
   localparam int DQT_SEGMENT_ITEMS = 69;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_result_kind;
   logic [2:0] rsp_marker_class;
   logic [7:0] rsp_marker_code;
   logic [3:0] rsp_table_number;
   logic [3:0] rsp_table_precision;
   logic [7:0] rsp_quant_value;
   logic [2:0] rsp_row_index;
   logic [2:0] rsp_col_index;
   logic       rsp_last_of_run;

   // stimulus and scoreboard
   logic [7:0]      stream_bytes [$];
   scan_result_type expected_results [$];
   scan_result_type oldest_result;
   int              planned_items = 0;
   int              stream_total = 0;
   int              bytes_sent = 0;
   int              results_seen = 0;
   int              mismatch_count = 0;

   // predictor state
   logic [5:0]      zz_natural [64];
   logic [7:0]      quant_mirror [64];
   parse_phase_type parse_state = SCAN_MARKERS;
   bit              prefix_seen = 1'b0;
   logic [5:0]      zz_pos = 6'd0;
   logic [3:0]      held_tbl_num = 4'd0;
   logic [3:0]      held_precision = 4'd0;

   // handshake bookkeeping between posedge sampling and negedge driving
   bit req_handed = 1'b0;
   bit rsp_handed = 1'b0;
   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;
   int req_gap = 0;
   int rsp_gap = 0;
   int rsp_hold = 0;

   jpeg_marker_scan_dqt_load_core u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_marker_class    (rsp_marker_class),
      .rsp_marker_code     (rsp_marker_code),
      .rsp_table_number    (rsp_table_number),
      .rsp_table_precision (rsp_table_precision),
      .rsp_quant_value     (rsp_quant_value),
      .rsp_row_index       (rsp_row_index),
      .rsp_col_index       (rsp_col_index),
      .rsp_last_of_run     (rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // walk the anti-diagonals: odd ones go down-left, even ones up-right
   function automatic void build_zigzag();
      int pos;
      int s;
      int r;
      int r_lo;
      int r_hi;
      pos = 0;
      for (s = 0; s < 15; s++) begin
         r_lo = (s > 7) ? s - 7 : 0;
         r_hi = (s < 7) ? s : 7;
         if (s % 2) begin
            for (r = r_lo; r <= r_hi; r++) begin
               zz_natural[6'(pos)] = 6'(r * 8 + (s - r));
               pos++;
            end
         end else begin
            for (r = r_hi; r >= r_lo; r--) begin
               zz_natural[6'(pos)] = 6'(r * 8 + (s - r));
               pos++;
            end
         end
      end
   endfunction

   // recognized marker codes and their class
   function automatic bit decode_marker(input logic [7:0] code,
                                        output jpgdqt_pkg::marker_class_type mclass);
      mclass = jpgdqt_pkg::CLASS_SOI;
      if (code == jpgdqt_pkg::SOI_CODE) mclass = jpgdqt_pkg::CLASS_SOI;
      else if (code == jpgdqt_pkg::APP0_CODE) mclass = jpgdqt_pkg::CLASS_APP0;
      else if (code >= jpgdqt_pkg::APPN_FIRST && code <= jpgdqt_pkg::APPN_LAST)
         mclass = jpgdqt_pkg::CLASS_APPN;
      else if (code == jpgdqt_pkg::DQT_CODE) mclass = jpgdqt_pkg::CLASS_DQT;
      else if (code == jpgdqt_pkg::SOF0_CODE) mclass = jpgdqt_pkg::CLASS_SOF0;
      else if (code == jpgdqt_pkg::DHT_CODE) mclass = jpgdqt_pkg::CLASS_DHT;
      else if (code == jpgdqt_pkg::SOS_CODE) mclass = jpgdqt_pkg::CLASS_SOS;
      else if (code == jpgdqt_pkg::EOI_CODE) mclass = jpgdqt_pkg::CLASS_EOI;
      else return 1'b0;
      return 1'b1;
   endfunction

   // advance the parser by one byte and queue whatever results it causes
   task automatic predict_scan_byte(input logic [7:0] b);
      scan_result_type r;
      jpgdqt_pkg::marker_class_type mclass;
      int k;
      case (parse_state)
         SKIP_LEN_HI: parse_state = SKIP_LEN_LO;
         SKIP_LEN_LO: parse_state = TAKE_INFO;
         TAKE_INFO: begin
            held_precision = b[7:4];
            held_tbl_num   = b[3:0];
            zz_pos         = 6'd0;
            parse_state    = TAKE_VALUES;
         end
         TAKE_VALUES: begin
            quant_mirror[zz_natural[zz_pos]] = b;
            if (zz_pos < 6'd63) begin
               zz_pos++;
            end else begin
               // full table: dump it in row-major order
               zz_pos      = 6'd0;
               parse_state = SCAN_MARKERS;
               prefix_seen = 1'b0;
               for (k = 0; k < 64; k++) begin
                  r.kind      = jpgdqt_pkg::KIND_ELEMENT;
                  r.mclass    = jpgdqt_pkg::CLASS_DQT;
                  r.code      = jpgdqt_pkg::DQT_CODE;
                  r.tbl_num   = held_tbl_num;
                  r.precision = held_precision;
                  r.value     = quant_mirror[6'(k)];
                  r.row       = 3'(k >> 3);
                  r.col       = 3'(k);
                  r.last      = (k == 63);
                  expected_results.push_back(r);
               end
            end
         end
         default: begin
            parse_state = SCAN_MARKERS;
            if (!prefix_seen) begin
               prefix_seen = (b == jpgdqt_pkg::PREFIX_CODE);
            end else if (b != jpgdqt_pkg::PREFIX_CODE) begin
               prefix_seen = 1'b0;
               if (decode_marker(b, mclass)) begin
                  r.kind      = jpgdqt_pkg::KIND_EVENT;
                  r.mclass    = mclass;
                  r.code      = b;
                  r.tbl_num   = 4'd0;
                  r.precision = 4'd0;
                  r.value     = 8'd0;
                  r.row       = 3'd0;
                  r.col       = 3'd0;
                  r.last      = 1'b1;
                  expected_results.push_back(r);
                  if (mclass == jpgdqt_pkg::CLASS_DQT) parse_state = SKIP_LEN_HI;
               end
            end
         end
      endcase
   endtask

   task automatic add_byte(input logic [7:0] b);
      stream_bytes.push_back(b);
      planned_items++;
   endtask

   task automatic add_marker(input logic [7:0] code);
      add_byte(jpgdqt_pkg::PREFIX_CODE);
      add_byte(code);
   endtask

   // dqt segment: marker, two length bytes, info byte, 64 zigzag values
   task automatic add_dqt_segment(input logic [7:0] info, input bit fixed_pattern);
      int k;
      logic [7:0] v;
      add_marker(jpgdqt_pkg::DQT_CODE);
      if (fixed_pattern) begin
         // length bytes that would look like a marker if scanned
         add_byte(jpgdqt_pkg::PREFIX_CODE);
         add_byte(jpgdqt_pkg::DQT_CODE);
      end else begin
         add_byte(8'($urandom_range(0, 255)));
         add_byte(8'($urandom_range(0, 255)));
      end
      add_byte(info);
      for (k = 0; k < 64; k++) begin
         if (fixed_pattern) begin
            if (k % 8 == 0 || k == 63) v = jpgdqt_pkg::PREFIX_CODE;
            else if (k % 8 == 1) v = jpgdqt_pkg::EOI_CODE;
            else if (k == 2) v = 8'h00;
            else v = 8'(k * 29 + 3);
         end else begin
            v = ($urandom_range(0, 4) == 0) ? jpgdqt_pkg::PREFIX_CODE
                                            : 8'($urandom_range(0, 255));
         end
         add_byte(v);
      end
   endtask

   task automatic build_random_stream();
      int sel;
      int n;
      logic [7:0] code;
      logic [7:0] info;
      jpgdqt_pkg::marker_class_type mclass;
      while (planned_items < STREAM_ITEMS) begin
         sel = $urandom_range(0, 99);
         if (sel < 15 && planned_items + DQT_SEGMENT_ITEMS <= STREAM_ITEMS) begin
            case ($urandom_range(0, 3))
               0: info = 8'h00;
               1: info = 8'hFF;
               default: info = 8'($urandom_range(0, 255));
            endcase
            add_dqt_segment(info, 1'b0);
         end else if (sel < 65) begin
            // well-formed marker, sometimes with extra fill bytes
            for (n = $urandom_range(0, 2); n > 0; n--) add_byte(jpgdqt_pkg::PREFIX_CODE);
            case ($urandom_range(0, 6))
               0: code = jpgdqt_pkg::SOI_CODE;
               1: code = jpgdqt_pkg::APP0_CODE;
               2: code = 8'($urandom_range(jpgdqt_pkg::APPN_FIRST, jpgdqt_pkg::APPN_LAST));
               3: code = jpgdqt_pkg::SOF0_CODE;
               4: code = jpgdqt_pkg::DHT_CODE;
               5: code = jpgdqt_pkg::SOS_CODE;
               default: code = jpgdqt_pkg::EOI_CODE;
            endcase
            add_marker(code);
         end else if (sel < 80) begin
            // prefix followed by stuffing or an unrecognized code
            if ($urandom_range(0, 2) == 0) begin
               code = 8'h00;
            end else begin
               code = 8'($urandom_range(0, 255));
               while (code == jpgdqt_pkg::PREFIX_CODE || decode_marker(code, mclass))
                  code = 8'($urandom_range(0, 255));
            end
            add_marker(code);
         end else begin
            // noise between segments
            for (n = $urandom_range(1, 4); n > 0; n--)
               add_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         predict_scan_byte(req_data_byte);
         bytes_sent++;
         req_handed = 1'b1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("result_kind: expected none, actual %0h (code %0h)",
                   rsp_result_kind, rsp_marker_code);
            mismatch_count++;
         end else begin
            oldest_result = expected_results.pop_front();
            check_field("result_kind", 8'(oldest_result.kind), 8'(rsp_result_kind));
            check_field("marker_class", 8'(oldest_result.mclass), 8'(rsp_marker_class));
            check_field("marker_code", oldest_result.code, rsp_marker_code);
            check_field("table_number", 8'(oldest_result.tbl_num), 8'(rsp_table_number));
            check_field("table_precision", 8'(oldest_result.precision),
                        8'(rsp_table_precision));
            check_field("quant_value", oldest_result.value, rsp_quant_value);
            check_field("row_index", 8'(oldest_result.row), 8'(rsp_row_index));
            check_field("col_index", 8'(oldest_result.col), 8'(rsp_col_index));
            check_field("last_of_run", 8'(oldest_result.last), 8'(rsp_last_of_run));
         end
         results_seen++;
         rsp_handed = 1'b1;
      end
   end

   // byte sender: next byte after a transfer, with a random gap per item
   always @(negedge clock) begin
      if (reset) begin
         req_valid     <= 1'b0;
         req_data_byte <= 8'd0;
      end else if (!req_valid || req_handed) begin
         req_handed = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (stream_bytes.size() > 0) begin
            req_valid     <= 1'b1;
            req_data_byte <= stream_bytes.pop_front();
            req_gap = req_burst ? 0 : $urandom_range(0, 4);
            // occasionally switch between gappy and back-to-back stretches
            if ($urandom_range(0, 39) == 0) req_burst = !req_burst;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver: random stall per result, up to two long hold-offs
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_handed) begin
            rsp_handed = 1'b0;
            rsp_gap = rsp_burst ? 0 : $urandom_range(0, 4);
            if ($urandom_range(0, 49) == 0) rsp_burst = !rsp_burst;
            // long stall while the sender keeps offering bytes
            if (results_seen == 6 || results_seen == 150) rsp_hold = 250;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      build_zigzag();

      // directed: every marker class, fill bytes, stuffing, unknown code
      add_marker(jpgdqt_pkg::SOI_CODE);
      add_byte(jpgdqt_pkg::PREFIX_CODE);
      add_marker(jpgdqt_pkg::APP0_CODE);
      add_marker(jpgdqt_pkg::APPN_FIRST);
      add_marker(jpgdqt_pkg::APPN_LAST);
      add_marker(8'h00);
      add_marker(8'h7F);
      add_byte(8'h5A);
      add_marker(jpgdqt_pkg::SOF0_CODE);
      add_marker(jpgdqt_pkg::DHT_CODE);
      add_marker(jpgdqt_pkg::SOS_CODE);
      // nonzero precision, payload full of prefix and marker bytes
      add_dqt_segment(8'hF0, 1'b1);
      // last value was a prefix byte, cleared by the dump: no event here
      add_byte(jpgdqt_pkg::EOI_CODE);
      // a second table in the same segment is just scanned
      add_byte(8'h01);
      add_byte(8'h02);
      add_marker(jpgdqt_pkg::EOI_CODE);

      build_random_stream();
      stream_total = stream_bytes.size();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (bytes_sent == stream_total);
      wait (expected_results.size() == 0);
      repeat (16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("jpeg_marker_scan_dqt_load_core: match");
      end else begin
         $display("jpeg_marker_scan_dqt_load_core: mismatch");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("jpeg_marker_scan_dqt_load_core: mismatch");
      $finish;
   end

endmodule
